>>> sv/cfb_pkg.sv
// cfb_pkg: constants, position codes and the crc-8 byte update for the frame builder
// no dependencies; used by crc8_frame_builder and crc8_frame_builder_checker
package cfb_pkg;

	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam logic [7:0] CRC_INIT    = 8'h00;
	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;
	localparam logic [7:0] TAIL_CR     = 8'h0D;
	localparam logic [7:0] TAIL_LF     = 8'h0A;
	localparam logic [7:0] LEN_RESET   = 8'd16;
	localparam logic [7:0] LEN_MIN     = 8'd1;

	// place of a word within the words one payload byte produces
	typedef enum logic [2:0] {
		POS_SYNC1 = 3'd0,
		POS_SYNC2 = 3'd1,
		POS_LEN   = 3'd2,
		POS_DATA  = 3'd3,
		POS_CRC   = 3'd4,
		POS_CR    = 3'd5,
		POS_LF    = 3'd6
	} pos_t;

	// crc-8, poly 0x07, msb first, one byte
	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> sv/crc8_frame_builder.sv
// crc8_frame_builder: wraps payload bytes into frames aa 55 len payload crc 0d 0a
// depends on cfb_pkg (constants, position codes, crc_feed)
//
//  channel | signals                                   | dir  | word
//  input   | in_valid, in_stall, payload_byte          | in   | one payload byte
//  output  | out_valid, out_stall, frame_byte,         | out  | one framed byte
//          | last_of_run, frame_end                    |      |
//  config  | cfg_valid, cfg_ready, payload_length      | in   | frame length
//
// each payload byte yields 1, 4 or 7 output words, one word per cycle while the
// output is not stalled; a byte with only its own word is taken every cycle
// unless the output stalls. crc and byte count are updated when the byte is
// accepted, so header and trailer words come from the input register alone.
// reset clears the count, the crc and both valid flags; length resets to 16.
// the input register refills in the cycle its last word moves to the output.
module crc8_frame_builder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] payload_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       last_of_run,
	output logic       frame_end,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] payload_length
);

	logic [7:0] length_q;
	logic [7:0] bytes_taken_q;
	logic [7:0] running_crc_q;

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic [7:0]     len_s1;
	logic [7:0]     crc_s1;
	logic           trl_s1;
	cfb_pkg::pos_t  pos_s1;

	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_end_q;
	logic       out_valid_q;

	logic          in_take;
	logic          out_load;
	logic          s1_done;
	logic [7:0]    len_eff;
	logic [7:0]    crc_base;
	logic [7:0]    crc_new;
	logic          closes;
	cfb_pkg::pos_t last_pos;
	logic [7:0]    word_byte;

	assign cfg_ready = 1'b1;

	assign len_eff  = (length_q == 8'd0) ? cfb_pkg::LEN_MIN : length_q;
	assign crc_base = (bytes_taken_q == 8'd0) ?
		cfb_pkg::crc_feed(cfb_pkg::CRC_INIT, len_eff) : running_crc_q;
	assign crc_new  = cfb_pkg::crc_feed(crc_base, payload_byte);
	assign closes   = ({1'b0, bytes_taken_q} + 9'd1) >= {1'b0, len_eff};

	assign last_pos = trl_s1 ? cfb_pkg::POS_LF : cfb_pkg::POS_DATA;
	assign out_load = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_done  = out_load && (pos_s1 == last_pos);
	assign in_stall = valid_s1 && !s1_done;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		case (pos_s1)
			cfb_pkg::POS_SYNC1: word_byte = cfb_pkg::SYNC_FIRST;
			cfb_pkg::POS_SYNC2: word_byte = cfb_pkg::SYNC_SECOND;
			cfb_pkg::POS_LEN:   word_byte = len_s1;
			cfb_pkg::POS_DATA:  word_byte = byte_s1;
			cfb_pkg::POS_CRC:   word_byte = crc_s1;
			cfb_pkg::POS_CR:    word_byte = cfb_pkg::TAIL_CR;
			cfb_pkg::POS_LF:    word_byte = cfb_pkg::TAIL_LF;
			default:            word_byte = byte_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= cfb_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			length_q <= payload_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_taken_q <= 8'd0;
			running_crc_q <= cfb_pkg::CRC_INIT;
		end else if (in_take) begin
			if (closes) begin
				bytes_taken_q <= 8'd0;
				running_crc_q <= cfb_pkg::CRC_INIT;
			end else begin
				bytes_taken_q <= bytes_taken_q + 8'd1;
				running_crc_q <= crc_new;
			end
		end
	end

	// input register: the accepted byte and what its words need
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_s1   <= cfb_pkg::POS_DATA;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
			pos_s1   <= (bytes_taken_q == 8'd0) ? cfb_pkg::POS_SYNC1 : cfb_pkg::POS_DATA;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (out_load) begin
			pos_s1 <= cfb_pkg::pos_t'(3'(pos_s1 + 3'd1));
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= payload_byte;
			len_s1  <= len_eff;
			crc_s1  <= crc_new;
			trl_s1  <= closes;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= word_byte;
			out_last_q <= (pos_s1 == last_pos);
			out_end_q  <= (pos_s1 == cfb_pkg::POS_LF);
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_byte  = out_byte_q;
	assign last_of_run = out_last_q;
	assign frame_end   = out_end_q;

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (pos_s1 <= last_pos))
		else $error("word position past the last word of its byte");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_end_q) |-> (out_last_q && out_byte_q == cfb_pkg::TAIL_LF))
		else $error("frame end not on the closing lf word of a byte");

	a_crc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_taken_q == 8'd0) |-> (running_crc_q == cfb_pkg::CRC_INIT))
		else $error("crc not cleared between frames");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && closes) |=> (bytes_taken_q == 8'd0 && trl_s1))
		else $error("closing byte did not restart the frame");
`endif

endmodule

>>> verif/crc8_frame_builder_checker.sv
`timescale 1ns / 1ps
// crc8_frame_builder_checker: watches the payload, frame and length channels,
// predicts every framed word and compares it with what the block sends
// depends on cfb_pkg for the framing constants
module crc8_frame_builder_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] payload_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] frame_byte,
	input  logic       last_of_run,
	input  logic       frame_end,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] payload_length,
	output int         errors,
	output int         pending
);

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_of_run;
		logic       frame_end;
	} frame_word_t;

	frame_word_t expected_words[$];
	logic [7:0]  frame_len;
	logic [7:0]  bytes_in_frame;
	logic [7:0]  crc_acc;

	// bit-serial form: feedback is the top crc bit against the next data bit
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ data[i];
			r = {r[6:0], 1'b0} ^ (fb ? cfb_pkg::CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	task automatic add_word(input logic [7:0] b, input logic fe);
		frame_word_t w;
		w.frame_byte = b;
		w.last_of_run = 1'b0;
		w.frame_end = fe;
		expected_words.push_back(w);
	endtask

	task automatic predict_frame_words(input logic [7:0] b);
		logic [7:0]  len;
		logic [7:0]  crc;
		frame_word_t w;
		// a zero length behaves as one byte per frame
		len = (frame_len == 8'd0) ? cfb_pkg::LEN_MIN : frame_len;
		crc = crc_acc;
		if (bytes_in_frame == 8'd0) begin
			add_word(cfb_pkg::SYNC_FIRST, 1'b0);
			add_word(cfb_pkg::SYNC_SECOND, 1'b0);
			add_word(len, 1'b0);
			crc = crc8_update(cfb_pkg::CRC_INIT, len);
		end
		add_word(b, 1'b0);
		crc = crc8_update(crc, b);
		// a length lowered mid-frame closes the frame on the next byte
		if ({1'b0, bytes_in_frame} + 9'd1 >= {1'b0, len}) begin
			add_word(crc, 1'b0);
			add_word(cfb_pkg::TAIL_CR, 1'b0);
			add_word(cfb_pkg::TAIL_LF, 1'b1);
			bytes_in_frame = 8'd0;
			crc_acc = cfb_pkg::CRC_INIT;
		end else begin
			bytes_in_frame = bytes_in_frame + 8'd1;
			crc_acc = crc;
		end
		w = expected_words.pop_back();
		w.last_of_run = 1'b1;
		expected_words.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_word_t want;
		if (!arst_n) begin
			expected_words.delete();
			frame_len = cfb_pkg::LEN_RESET;
			bytes_in_frame = 8'd0;
			crc_acc = cfb_pkg::CRC_INIT;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frame_len = payload_length;
			end
			if (in_valid && !in_stall) begin
				predict_frame_words(payload_byte);
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("frame_byte 0x%02h arrived with no word expected", frame_byte);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (frame_byte !== want.frame_byte) begin
						$error("frame_byte: expected 0x%02h, got 0x%02h",
							want.frame_byte, frame_byte);
						errors++;
					end
					if (last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0b, got %0b",
							want.last_of_run, last_of_run);
						errors++;
					end
					if (frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
						errors++;
					end
				end
			end
		end
		pending <= expected_words.size();
	end

endmodule

>>> verif/crc8_frame_builder_test.sv
`timescale 1ns / 1ps
// crc8_frame_builder_test: drives payload bytes and length writes into the
// frame builder with random idling; checking is done in crc8_frame_builder_checker
// depends on crc8_frame_builder and crc8_frame_builder_checker
module crc8_frame_builder_test;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SEGMENTS      = 3;
	localparam int SEGMENT_BYTES = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] payload_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] frame_byte;
	logic       last_of_run;
	logic       frame_end;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] payload_length = 8'h00;

	int errors;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;

	crc8_frame_builder i_dut (.*);

	crc8_frame_builder_checker i_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= (int'($urandom_range(0, 99)) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// valid stays high into the next word unless an idle gap is drawn
	task automatic send_byte(input logic [7:0] b);
		payload_byte <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (int'($urandom_range(0, 99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_length(input logic [7:0] len);
		payload_length <= len;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start a frame at the reset length, then cut it short with a zero length
		send_byte(8'h00);
		send_byte(8'hFF);
		wait_drained();
		write_length(8'd0);
		send_byte(8'h5A);
		send_byte(8'h01);
		wait_drained();
		write_length(8'd255);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'hAA);
		wait_drained();
		write_length(8'd2);
		send_byte(8'h55);
		wait_drained();
		write_length(8'd1);
		send_byte(8'hFE);
		wait_drained();
		write_length(8'd3);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 17;
					recv_stall_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				// mostly short frames so many frames close; some longer ones
				wait_drained();
				write_length(($urandom_range(0, 3) == 0) ? 8'($urandom_range(11, 24))
					: 8'($urandom_range(0, 10)));
				for (int i = 0; i < SEGMENT_BYTES; i++) begin
					send_byte(8'($urandom_range(0, 255)));
				end
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
